@@ sv/ilir_pkg.sv @@
package ilir_pkg;

  localparam int CAPACITY  = 64;
  localparam int WORD_BITS = 32;
  localparam int IDX_W     = 7;
  localparam int LEN_W     = 7;
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int CMP_W     = (CNT_W > IDX_W) ? CNT_W : IDX_W;
  localparam int GROUP     = 8;
  localparam int NUM_GROUPS = (CAPACITY + GROUP - 1) / GROUP;

  typedef enum logic [2:0] {
    OP_APPEND  = 3'd0,
    OP_INSERT  = 3'd1,
    OP_READ    = 3'd2,
    OP_REMOVE  = 3'd3,
    OP_REPLACE = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef logic [WORD_BITS-1:0] word_t;

  typedef struct packed {
    logic             en;
    op_e              op;
    logic [CMP_W-1:0] pos;
    word_t            value;
  } cell_ctrl_t;

endpackage

@@ sv/ilir_cell.sv @@
module ilir_cell (
  input  logic                            clk_i,
  input  ilir_pkg::cell_ctrl_t            ctrl_i,
  input  logic [ilir_pkg::CMP_W-1:0]      cell_idx_i,
  input  ilir_pkg::word_t                 left_i,
  input  ilir_pkg::word_t                 right_i,
  output ilir_pkg::word_t                 word_o
);

  ilir_pkg::word_t word_q;
  ilir_pkg::word_t word_d;
  logic            eq;
  logic            gt;

  assign eq = (cell_idx_i == ctrl_i.pos);
  assign gt = (cell_idx_i > ctrl_i.pos);

  always_comb begin
    word_d = word_q;
    case (ctrl_i.op) inside
      ilir_pkg::OP_APPEND, ilir_pkg::OP_REPLACE: begin
        if (eq) word_d = ctrl_i.value;
      end
      ilir_pkg::OP_INSERT: begin
        if (eq) word_d = ctrl_i.value;
        else if (gt) word_d = left_i;
      end
      ilir_pkg::OP_REMOVE: begin
        if (eq || gt) word_d = right_i;
      end
      default: word_d = word_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en) word_q <= word_d;
  end

  assign word_o = word_q;

endmodule

@@ sv/indexed_list_insert_remove.sv @@
// A request is accepted in S_IDLE, where the group reductions are registered; the
// result is registered from S_READ once the output is free.
// A new request is not taken until the result is registered; S_READ is the registered
// read reduction over the cell row (groups of 8, then across groups).
// A stalled result holds in_stall_o high once the next request is taken.
// Shifts for insert and remove happen in the accept cycle, in the cells above the position (and at it, for remove).
// Reset: length clears to zero; list words are undefined until written.
module indexed_list_insert_remove (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [2:0]                      op_i,
  input  logic [ilir_pkg::IDX_W-1:0]      index_i,
  input  logic [31:0]                     value_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [31:0]                     read_value_o,
  output logic [1:0]                      status_o,
  output logic [ilir_pkg::LEN_W-1:0]      length_o
);

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_e;

  state_e                           state_q;
  logic [ilir_pkg::CNT_W-1:0]       count_q;
  logic [ilir_pkg::CNT_W-1:0]       count_d;
  ilir_pkg::word_t                  grp_q [ilir_pkg::NUM_GROUPS];
  ilir_pkg::word_t                  grp_d [ilir_pkg::NUM_GROUPS];
  logic                             rd_en_q;
  ilir_pkg::status_e                st_q;
  ilir_pkg::status_e                st_d;
  logic                             ok;
  logic                             accept;
  logic                             out_free;
  logic [ilir_pkg::CMP_W-1:0]       idx_x;
  logic [ilir_pkg::CMP_W-1:0]       cnt_x;
  logic                             full;
  ilir_pkg::cell_ctrl_t             ctrl;
  ilir_pkg::word_t                  words [ilir_pkg::CAPACITY];
  ilir_pkg::word_t                  rd_sum;

  assign in_stall_o = (state_q == S_READ);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_o || !out_stall_i;

  assign idx_x = ilir_pkg::CMP_W'(index_i);
  assign cnt_x = ilir_pkg::CMP_W'(count_q);
  assign full  = (cnt_x >= ilir_pkg::CMP_W'(ilir_pkg::CAPACITY));

  always_comb begin
    st_d    = ilir_pkg::ST_OK;
    count_d = count_q;
    unique case (op_i) inside
      ilir_pkg::OP_APPEND: begin
        if (full) st_d = ilir_pkg::ST_FULL;
        else count_d = count_q + 1'b1;
      end
      ilir_pkg::OP_INSERT: begin
        if (idx_x > cnt_x) st_d = ilir_pkg::ST_RANGE;
        else if (full) st_d = ilir_pkg::ST_FULL;
        else count_d = count_q + 1'b1;
      end
      ilir_pkg::OP_READ, ilir_pkg::OP_REPLACE: begin
        if (idx_x >= cnt_x) st_d = ilir_pkg::ST_RANGE;
      end
      ilir_pkg::OP_REMOVE: begin
        if (idx_x >= cnt_x) st_d = ilir_pkg::ST_RANGE;
        else count_d = count_q - 1'b1;
      end
      default: st_d = ilir_pkg::ST_RANGE;
    endcase
  end

  assign ok = (st_d == ilir_pkg::ST_OK);

  always_comb begin
    ctrl.en    = accept && ok;
    ctrl.op    = ilir_pkg::op_e'(op_i);
    ctrl.pos   = (op_i == ilir_pkg::OP_APPEND) ? cnt_x : idx_x;
    ctrl.value = ilir_pkg::word_t'(value_i);
  end

  for (genvar n = 0; n < ilir_pkg::CAPACITY; n++) begin : g_cell
    ilir_pkg::word_t left_w;
    ilir_pkg::word_t right_w;
    if (n == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = words[n-1];
    end
    if (n == ilir_pkg::CAPACITY - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = words[n+1];
    end
    ilir_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .cell_idx_i (ilir_pkg::CMP_W'(n)),
      .left_i     (left_w),
      .right_i    (right_w),
      .word_o     (words[n])
    );
  end

  // gated OR over each group of cells, selected by index
  always_comb begin
    for (int g = 0; g < ilir_pkg::NUM_GROUPS; g++) begin
      grp_d[g] = '0;
      for (int j = 0; j < ilir_pkg::GROUP; j++) begin
        if (g * ilir_pkg::GROUP + j < ilir_pkg::CAPACITY) begin
          if (idx_x == ilir_pkg::CMP_W'(g * ilir_pkg::GROUP + j)) begin
            grp_d[g] = grp_d[g] | words[g * ilir_pkg::GROUP + j];
          end
        end
      end
    end
  end

  always_comb begin
    rd_sum = '0;
    for (int g = 0; g < ilir_pkg::NUM_GROUPS; g++) begin
      rd_sum = rd_sum | grp_q[g];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      count_q      <= '0;
      rd_en_q      <= 1'b0;
      st_q         <= ilir_pkg::ST_OK;
      out_valid_o  <= 1'b0;
      read_value_o <= '0;
      status_o     <= '0;
      length_o     <= '0;
      for (int g = 0; g < ilir_pkg::NUM_GROUPS; g++) grp_q[g] <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (out_valid_o && !out_stall_i) out_valid_o <= 1'b0;
          if (accept) begin
            state_q <= S_READ;
            count_q <= count_d;
            rd_en_q <= ok && (op_i == ilir_pkg::OP_READ);
            st_q    <= st_d;
            for (int g = 0; g < ilir_pkg::NUM_GROUPS; g++) grp_q[g] <= grp_d[g];
          end
        end
        S_READ: begin
          if (out_free) begin
            state_q      <= S_IDLE;
            out_valid_o  <= 1'b1;
            read_value_o <= 32'(rd_en_q ? rd_sum : '0);
            status_o     <= st_q;
            length_o     <= ilir_pkg::LEN_W'(count_q);
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

@@ tb/indexed_list_insert_remove_tb.sv @@
module indexed_list_insert_remove_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD      = 10;
  localparam int RESET_CYCLES    = 8;
  localparam int RANDOM_REQUESTS = 450;
  localparam int HOLD_CYCLES     = 120;
  localparam int DRAIN_CYCLES    = 8;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int FULL_VISITS     = 6;
  localparam int DIRECTED_ROWS   = 25;

  // op codes the block does not define
  localparam logic [2:0] OP_RSVD5 = 3'd5;
  localparam logic [2:0] OP_RSVD6 = 3'd6;
  localparam logic [2:0] OP_RSVD7 = 3'd7;

  typedef struct {
    ilir_pkg::word_t             rd;
    ilir_pkg::status_e           st;
    logic [ilir_pkg::LEN_W-1:0]  len;
  } list_result_t;

  typedef struct {
    logic [2:0]                  op;
    logic [ilir_pkg::IDX_W-1:0]  idx;
    ilir_pkg::word_t             val;
    bit                          fixed;
    ilir_pkg::word_t             rd;
    ilir_pkg::status_e           st;
    logic [ilir_pkg::LEN_W-1:0]  len;
  } request_row_t;

  logic                        clk_i       = 1'b0;
  logic                        rst_ni      = 1'b0;
  logic                        in_valid_i  = 1'b0;
  logic [2:0]                  op_i        = ilir_pkg::OP_APPEND;
  logic [ilir_pkg::IDX_W-1:0]  index_i     = '0;
  logic [31:0]                 value_i     = '0;
  logic                        out_stall_i = 1'b0;
  logic                        in_stall_o;
  logic                        out_valid_o;
  logic [31:0]                 read_value_o;
  logic [1:0]                  status_o;
  logic [ilir_pkg::LEN_W-1:0]  length_o;

  ilir_pkg::word_t list_words [ilir_pkg::CAPACITY];
  int              list_len = 0;
  list_result_t    expected_results [$];
  list_result_t    oldest;
  int              mismatches  = 0;
  int              cycles      = 0;
  int              burst_left  = 0;
  bit              start_hold  = 1'b0;
  bit              hold_done   = 1'b0;

  // directed rows: typed results only after reset, at extremes and on rejects
  request_row_t directed_rows [DIRECTED_ROWS] = '{
    '{ilir_pkg::OP_READ,    7'd0,   32'h0,        1'b1, 32'h0, ilir_pkg::ST_RANGE, 7'd0},
    '{ilir_pkg::OP_REMOVE,  7'd0,   32'h0,        1'b1, 32'h0, ilir_pkg::ST_RANGE, 7'd0},
    '{ilir_pkg::OP_REPLACE, 7'd0,   32'hDEADBEEF, 1'b1, 32'h0, ilir_pkg::ST_RANGE, 7'd0},
    '{ilir_pkg::OP_INSERT,  7'd1,   32'h1,        1'b1, 32'h0, ilir_pkg::ST_RANGE, 7'd0},
    '{OP_RSVD5,             7'd0,   32'h0,        1'b1, 32'h0, ilir_pkg::ST_RANGE, 7'd0},
    '{OP_RSVD6,             7'd127, 32'hFFFFFFFF, 1'b1, 32'h0, ilir_pkg::ST_RANGE, 7'd0},
    '{OP_RSVD7,             7'd64,  32'h0,        1'b1, 32'h0, ilir_pkg::ST_RANGE, 7'd0},
    '{ilir_pkg::OP_APPEND,  7'd127, 32'hFFFFFFFF, 1'b1, 32'h0, ilir_pkg::ST_OK,    7'd1},
    '{ilir_pkg::OP_INSERT,  7'd0,   32'h0,        1'b1, 32'h0, ilir_pkg::ST_OK,    7'd2},
    '{ilir_pkg::OP_INSERT,  7'd2,   32'hA5A5A5A5, 1'b1, 32'h0, ilir_pkg::ST_OK,    7'd3},
    '{ilir_pkg::OP_READ,    7'd0,   32'h0,        1'b0, 32'h0, ilir_pkg::ST_OK,    7'd0},
    '{ilir_pkg::OP_READ,    7'd1,   32'hFFFFFFFF, 1'b0, 32'h0, ilir_pkg::ST_OK,    7'd0},
    '{ilir_pkg::OP_READ,    7'd2,   32'h0,        1'b0, 32'h0, ilir_pkg::ST_OK,    7'd0},
    '{ilir_pkg::OP_READ,    7'd3,   32'h0,        1'b1, 32'h0, ilir_pkg::ST_RANGE, 7'd3},
    '{ilir_pkg::OP_REPLACE, 7'd1,   32'h12345678, 1'b1, 32'h0, ilir_pkg::ST_OK,    7'd3},
    '{ilir_pkg::OP_READ,    7'd1,   32'h0,        1'b0, 32'h0, ilir_pkg::ST_OK,    7'd0},
    '{ilir_pkg::OP_INSERT,  7'd1,   32'h5A5A5A5A, 1'b0, 32'h0, ilir_pkg::ST_OK,    7'd0},
    '{ilir_pkg::OP_REMOVE,  7'd0,   32'h0,        1'b0, 32'h0, ilir_pkg::ST_OK,    7'd0},
    '{ilir_pkg::OP_READ,    7'd0,   32'h0,        1'b0, 32'h0, ilir_pkg::ST_OK,    7'd0},
    '{ilir_pkg::OP_REMOVE,  7'd2,   32'h0,        1'b0, 32'h0, ilir_pkg::ST_OK,    7'd0},
    '{ilir_pkg::OP_READ,    7'd127, 32'h0,        1'b1, 32'h0, ilir_pkg::ST_RANGE, 7'd2},
    '{ilir_pkg::OP_INSERT,  7'd3,   32'hFFFFFFFF, 1'b1, 32'h0, ilir_pkg::ST_RANGE, 7'd2},
    '{ilir_pkg::OP_REMOVE,  7'd1,   32'h0,        1'b0, 32'h0, ilir_pkg::ST_OK,    7'd0},
    '{ilir_pkg::OP_REMOVE,  7'd0,   32'h0,        1'b0, 32'h0, ilir_pkg::ST_OK,    7'd0},
    '{ilir_pkg::OP_APPEND,  7'd0,   32'h0,        1'b0, 32'h0, ilir_pkg::ST_OK,    7'd0}
  };

  indexed_list_insert_remove u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .op_i         (op_i),
    .index_i      (index_i),
    .value_i      (value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .read_value_o (read_value_o),
    .status_o     (status_o),
    .length_o     (length_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // applies one request to the list copy and returns its result
  function automatic list_result_t apply_request(input logic [2:0] op,
                                                 input logic [ilir_pkg::IDX_W-1:0] idx,
                                                 input ilir_pkg::word_t val);
    list_result_t r;
    int pos;
    pos  = idx;
    r.rd = '0;
    r.st = ilir_pkg::ST_OK;
    case (op)
      ilir_pkg::OP_APPEND: begin
        if (list_len >= ilir_pkg::CAPACITY) begin
          r.st = ilir_pkg::ST_FULL;
        end else begin
          list_words[list_len] = val;
          list_len++;
        end
      end
      ilir_pkg::OP_INSERT: begin
        if (pos > list_len) begin
          r.st = ilir_pkg::ST_RANGE;
        end else if (list_len >= ilir_pkg::CAPACITY) begin
          r.st = ilir_pkg::ST_FULL;
        end else begin
          for (int i = list_len; i > pos; i--) list_words[i] = list_words[i-1];
          list_words[pos] = val;
          list_len++;
        end
      end
      ilir_pkg::OP_READ: begin
        if (pos >= list_len) r.st = ilir_pkg::ST_RANGE;
        else r.rd = list_words[pos];
      end
      ilir_pkg::OP_REMOVE: begin
        if (pos >= list_len) begin
          r.st = ilir_pkg::ST_RANGE;
        end else begin
          for (int i = pos; i + 1 < list_len; i++) list_words[i] = list_words[i+1];
          list_len--;
        end
      end
      ilir_pkg::OP_REPLACE: begin
        if (pos >= list_len) r.st = ilir_pkg::ST_RANGE;
        else list_words[pos] = val;
      end
      default: r.st = ilir_pkg::ST_RANGE;
    endcase
    r.len = ilir_pkg::LEN_W'(list_len);
    return r;
  endfunction

  task automatic send_request(input logic [2:0] op,
                              input logic [ilir_pkg::IDX_W-1:0] idx,
                              input ilir_pkg::word_t val, input bit fixed,
                              input list_result_t fixed_res);
    list_result_t res;
    op_i       <= op;
    index_i    <= idx;
    value_i    <= val;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    res = apply_request(op, idx, val);
    expected_results.push_back(fixed ? fixed_res : res);
  endtask

  // bursts of back-to-back requests with random gaps between them
  task automatic pace_sender();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
  endtask

  initial begin : stimulus
    list_result_t                fixed_res;
    logic [2:0]                  op;
    logic [ilir_pkg::IDX_W-1:0]  idx;
    int                          pick;
    bit                          filling;
    int                          full_hits;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[n]) begin
      fixed_res.rd  = directed_rows[n].rd;
      fixed_res.st  = directed_rows[n].st;
      fixed_res.len = directed_rows[n].len;
      send_request(directed_rows[n].op, directed_rows[n].idx, directed_rows[n].val,
                   directed_rows[n].fixed, fixed_res);
      pace_sender();
    end

    start_hold = 1'b1;
    filling    = 1'b1;
    full_hits  = 0;
    repeat (RANDOM_REQUESTS) begin
      pick = $urandom_range(0, 99);
      if (filling) begin
        op = (pick < 40) ? ilir_pkg::OP_APPEND :
             (pick < 65) ? ilir_pkg::OP_INSERT :
             (pick < 80) ? ilir_pkg::OP_READ :
             (pick < 88) ? ilir_pkg::OP_REPLACE :
             (pick < 96) ? ilir_pkg::OP_REMOVE : 3'(OP_RSVD5 + $urandom_range(0, 2));
      end else begin
        op = (pick < 8)  ? ilir_pkg::OP_APPEND :
             (pick < 16) ? ilir_pkg::OP_INSERT :
             (pick < 36) ? ilir_pkg::OP_READ :
             (pick < 46) ? ilir_pkg::OP_REPLACE :
             (pick < 96) ? ilir_pkg::OP_REMOVE : 3'(OP_RSVD5 + $urandom_range(0, 2));
      end
      if ($urandom_range(0, 9) == 0 || (filling && list_len == ilir_pkg::CAPACITY)) begin
        idx = ilir_pkg::IDX_W'($urandom_range(0, 127));
      end else if (op == ilir_pkg::OP_INSERT) begin
        idx = ilir_pkg::IDX_W'($urandom_range(0, list_len));
      end else begin
        idx = (list_len == 0) ? '0 : ilir_pkg::IDX_W'($urandom_range(0, list_len - 1));
      end
      if (list_len == ilir_pkg::CAPACITY) full_hits++;
      if (filling && full_hits >= FULL_VISITS) begin
        filling = 1'b0;
      end else if (!filling && list_len == 0) begin
        filling   = 1'b1;
        full_hits = 0;
      end
      send_request(op, idx, $urandom, 1'b0, fixed_res);
      pace_sender();
    end
    in_valid_i <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // receiver stall pattern, plus one long hold-off to back the block up
  initial begin : receiver
    int mode;
    int span;
    forever begin
      if (start_hold && !hold_done) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_done = 1'b1;
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(1, 30);
      repeat (span) begin
        out_stall_i <= (mode == 0) ? 1'b0 :
                       (mode == 1) ? ($urandom_range(0, 3) == 0) :
                       (mode == 2) ? 1'($urandom_range(0, 1)) :
                       ($urandom_range(0, 3) != 0);
        @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual rd=%h st=%0d len=%0d",
                 $time, read_value_o, status_o, length_o);
        mismatches++;
      end else begin
        oldest = expected_results.pop_front();
        if (read_value_o !== oldest.rd) begin
          $display("%0t: read_value expected %h actual %h", $time, oldest.rd, read_value_o);
          mismatches++;
        end
        if (status_o !== oldest.st) begin
          $display("%0t: status expected %0d actual %0d", $time, oldest.st, status_o);
          mismatches++;
        end
        if (length_o !== oldest.len) begin
          $display("%0t: length expected %0d actual %0d", $time, oldest.len, length_o);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results outstanding", $time, expected_results.size());
      $display("simulation failed");
      $finish;
    end
  end

endmodule
